@@ rtl/core/srcf_pkg.sv @@
// Shared types and fixed field widths for the step result cache.
// No dependencies; every other file in this block imports it.
package srcf_pkg;

	localparam int CFG_W      = 4;
	localparam int IDX_OUT_W  = 3;
	localparam int STEP_OUT_W = 32;

	typedef enum logic {
		CMD_SELECT = 1'b0,
		CMD_MARK   = 1'b1
	} cmd_t;

	// control from the sequencer to the distance unit
	typedef struct packed {
		logic en;
		logic first;
	} far_ctl_t;

endpackage

@@ rtl/core/srcf_if.sv @@
// Valid/ready channel interfaces: command input, result output and config write.
// Depends on srcf_pkg.
interface srcf_cmd_if;
	import srcf_pkg::*;
	logic                         valid;
	logic                         ready;
	cmd_t                         command;
	logic signed [STEP_OUT_W-1:0] step_value;
	logic                         up_to_date;
	modport source (output valid, command, step_value, up_to_date, input ready);
	modport sink (input valid, command, step_value, up_to_date, output ready);
endinterface

interface srcf_rsp_if;
	import srcf_pkg::*;
	logic                         valid;
	logic                         ready;
	logic        [IDX_OUT_W-1:0]  current_index;
	logic signed [STEP_OUT_W-1:0] current_step;
	logic                         current_valid;
	logic                         was_hit;
	modport source (output valid, current_index, current_step, current_valid, was_hit,
		input ready);
	modport sink (input valid, current_index, current_step, current_valid, was_hit,
		output ready);
endinterface

interface srcf_cfg_if;
	import srcf_pkg::*;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ rtl/core/srcf_far_unit.sv @@
// Shared distance unit: one subtract, magnitude and compare per cycle,
// keeping the running farthest entry. Depends on srcf_pkg.
module srcf_far_unit #(
	parameter int DW = 32,
	parameter int IW = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  srcf_pkg::far_ctl_t    ctl,
	input  logic signed [DW-1:0]  entry_val,
	input  logic signed [DW-1:0]  req_val,
	input  logic        [IW-1:0]  entry_idx,
	output logic        [IW-1:0]  far_idx
);
	import srcf_pkg::*;

	logic signed [DW:0] diff;
	logic        [DW:0] mag;
	logic        [DW:0] far_dist_q;
	logic        [IW-1:0] far_idx_q;

	assign diff = (DW+1)'(entry_val) - (DW+1)'(req_val);
	assign mag  = diff[DW] ? (DW+1)'(-diff) : (DW+1)'(diff);

	// strict greater: the lowest index keeps ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			far_idx_q <= '0;
		end else if (ctl.en && (ctl.first || mag > far_dist_q)) begin
			far_idx_q <= entry_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en && (ctl.first || mag > far_dist_q)) begin
			far_dist_q <= mag;
		end
	end

	assign far_idx = far_idx_q;
endmodule

@@ rtl/core/step_result_cache_farthest_replace_unit.sv @@
// Top level of the step result cache with farthest-value replacement.
// Depends on srcf_pkg, the channel interfaces in srcf_if and srcf_far_unit.
//
// Fully associative cache of MAX_ENTRIES signed fixed-point step values
// (STEP_BITS wide, Q16.16 at the default), each with an up-to-date flag, one
// entry current. A select transaction compares the request against the
// current entry, then scans the entries in use for a match, and on a miss
// scans them again through a single distance unit and overwrites the entry
// farthest from the request (lowest index on ties), clearing its flag. A mark
// transaction writes the current entry's flag. Every command transaction
// yields exactly one result transaction describing the current entry.
// The command channel takes one transaction at a time. Mark, a current-entry
// hit and a miss with one entry in use (overwritten in place) finish once the
// current entry is read; a hit found by the scan ends the match scan there;
// any other miss runs the match scan and the farthest-distance scan over all
// entries in use, then a replace step. The result register loads as the
// sequencer returns to idle, before the next command can be taken. Each scan
// walks one entry per cycle through the store's single registered read port.
// A finished result waits in the output register while the next command is
// taken. The entries_in_use register (0 acts as 1, values above MAX_ENTRIES
// act as MAX_ENTRIES) may only be written while no command is in flight.
module step_result_cache_farthest_replace_unit #(
	parameter int MAX_ENTRIES = 8,
	parameter int STEP_BITS   = 32
) (
	input logic      clk,
	input logic      arst_n,
	srcf_cmd_if.sink   cmd,
	srcf_rsp_if.source rsp,
	srcf_cfg_if.sink   cfg
);
	import srcf_pkg::*;

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CUR,
		S_MATCH,
		S_FAR,
		S_REPL,
		S_DONE
	} state_t;

	state_t                       state_q;
	logic        [CFG_W-1:0]      entries_q;
	logic        [IDX_W-1:0]      cur_q;
	logic        [IDX_W-1:0]      chk_q;
	logic        [MAX_ENTRIES-1:0] fresh_q;
	logic        [MAX_ENTRIES-1:0] vld_q;
	cmd_t                         cmd_q;
	logic signed [STEP_BITS-1:0]  req_q;
	logic                         upd_q;

	// entry store with one registered read port
	logic signed [STEP_BITS-1:0]  mem [MAX_ENTRIES];
	logic signed [STEP_BITS-1:0]  rd_q;
	logic                         rd_vld_q;
	logic signed [STEP_BITS-1:0]  rd_val;
	logic        [IDX_W-1:0]      rd_addr;
	logic                         wr_en;
	logic        [IDX_W-1:0]      wr_addr;

	// result staging and output register
	logic        [IDX_W-1:0]      res_idx_q;
	logic signed [STEP_BITS-1:0]  res_step_q;
	logic                         res_fresh_q;
	logic                         res_hit_q;
	logic                         out_valid_q;
	logic        [IDX_W-1:0]      out_idx_q;
	logic signed [STEP_BITS-1:0]  out_step_q;
	logic                         out_fresh_q;
	logic                         out_hit_q;

	logic        [CNT_W-1:0]      act_n;
	logic                         chk_last;
	logic                         cmd_acc;
	logic                         out_free;
	logic                         entry_eq;
	far_ctl_t                     far_ctl;
	logic        [IDX_W-1:0]      far_idx;

	// clamp the configured count into 1..MAX_ENTRIES
	always_comb begin
		if (entries_q == '0) begin
			act_n = CNT_W'(1);
		end else if (CMP_W'(entries_q) > CMP_W'(MAX_ENTRIES)) begin
			act_n = CNT_W'(MAX_ENTRIES);
		end else begin
			act_n = CNT_W'(entries_q);
		end
	end

	assign chk_last = (CNT_W'(chk_q) == act_n - CNT_W'(1));
	assign cmd_acc  = cmd.valid && cmd.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign rd_val   = rd_vld_q ? rd_q : '0;
	assign entry_eq = (rd_val == req_q);

	assign cmd.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= CFG_W'(8);
		end else if (cfg.valid && cfg.ready) begin
			entries_q <= cfg.data;
		end
	end

	// read address: the current entry by default, the next scan slot while scanning
	always_comb begin
		rd_addr = cur_q;
		case (state_q)
			S_CUR: begin
				rd_addr = '0;
			end
			S_MATCH: begin
				rd_addr = chk_last ? '0 : IDX_W'(chk_q + IDX_W'(1));
			end
			S_FAR: begin
				rd_addr = IDX_W'(chk_q + IDX_W'(1));
			end
			default: begin
				rd_addr = cur_q;
			end
		endcase
	end

	// write the request into an entry: single-entry overwrite or farthest replace
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cur_q;
		if (state_q == S_CUR && cmd_q == CMD_SELECT && !entry_eq && act_n == CNT_W'(1)) begin
			wr_en = 1'b1;
		end else if (state_q == S_REPL) begin
			wr_en   = 1'b1;
			wr_addr = far_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= req_q;
		end
		rd_q <= mem[rd_addr];
	end

	// written marks: an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	// distance unit runs on the second scan only
	assign far_ctl.en    = (state_q == S_FAR);
	assign far_ctl.first = (chk_q == '0);

	srcf_far_unit #(
		.DW(STEP_BITS),
		.IW(IDX_W)
	) u_far (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (far_ctl),
		.entry_val(rd_val),
		.req_val  (req_q),
		.entry_idx(chk_q),
		.far_idx  (far_idx)
	);

	// sequencer: state, flags, current entry and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_q       <= '0;
			chk_q       <= '0;
			fresh_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drop the result once taken, unless a new one loads this cycle
			if (out_valid_q && rsp.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					// latch the command; the current entry's read is issued now
					if (cmd_acc) begin
						state_q <= S_CUR;
					end
				end
				S_CUR: begin
					res_idx_q <= cur_q;
					if (cmd_q == CMD_MARK) begin
						fresh_q[cur_q] <= upd_q;
						res_step_q     <= rd_val;
						res_fresh_q    <= upd_q;
						res_hit_q      <= 1'b0;
						state_q        <= S_DONE;
					end else if (entry_eq) begin
						// current entry already holds the value
						res_step_q  <= rd_val;
						res_fresh_q <= fresh_q[cur_q];
						res_hit_q   <= 1'b1;
						state_q     <= S_DONE;
					end else if (act_n == CNT_W'(1)) begin
						// single entry: overwrite in place
						fresh_q[cur_q] <= 1'b0;
						res_step_q     <= req_q;
						res_fresh_q    <= 1'b0;
						res_hit_q      <= 1'b0;
						state_q        <= S_DONE;
					end else begin
						chk_q   <= '0;
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					if (entry_eq) begin
						cur_q       <= chk_q;
						res_idx_q   <= chk_q;
						res_step_q  <= req_q;
						res_fresh_q <= fresh_q[chk_q];
						res_hit_q   <= 1'b1;
						state_q     <= S_DONE;
					end else if (chk_last) begin
						chk_q   <= '0;
						state_q <= S_FAR;
					end else begin
						chk_q <= IDX_W'(chk_q + IDX_W'(1));
					end
				end
				S_FAR: begin
					if (chk_last) begin
						state_q <= S_REPL;
					end else begin
						chk_q <= IDX_W'(chk_q + IDX_W'(1));
					end
				end
				S_REPL: begin
					fresh_q[far_idx] <= 1'b0;
					cur_q            <= far_idx;
					res_idx_q        <= far_idx;
					res_step_q       <= req_q;
					res_fresh_q      <= 1'b0;
					res_hit_q        <= 1'b0;
					state_q          <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_idx_q   <= res_idx_q;
						out_step_q  <= res_step_q;
						out_fresh_q <= res_fresh_q;
						out_hit_q   <= res_hit_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// command payload capture
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			cmd_q <= cmd.command;
			req_q <= STEP_BITS'(cmd.step_value);
			upd_q <= cmd.up_to_date;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.current_index = IDX_OUT_W'(out_idx_q);
	assign rsp.current_step  = STEP_OUT_W'(out_step_q);
	assign rsp.current_valid = out_fresh_q;
	assign rsp.was_hit       = out_hit_q;
endmodule

@@ tb/step_result_cache_farthest_replace_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for step_result_cache_farthest_replace_unit.
// Depends on srcf_pkg, the srcf_if channel interfaces and the unit itself.
module step_result_cache_farthest_replace_unit_tb;
	import srcf_pkg::*;

	localparam int CACHE_DEPTH = 8;
	localparam int SETTLE_CYCLES = 30;

	// one result transaction as the unit reports it
	typedef struct packed {
		logic [IDX_OUT_W-1:0]         index;
		logic signed [STEP_OUT_W-1:0] step;
		logic                         flag;
		logic                         hit;
	} cache_result_t;

	logic clk;
	logic arst_n;

	srcf_cmd_if cmd_ch();
	srcf_rsp_if rsp_ch();
	srcf_cfg_if cfg_ch();

	step_result_cache_farthest_replace_unit dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.rsp   (rsp_ch),
		.cfg   (cfg_ch)
	);

	// Shadow copy of the cache: values, up-to-date flags, current entry and
	// the entries-in-use register, advanced once per accepted command.
	logic signed [STEP_OUT_W-1:0] cache_step [CACHE_DEPTH];
	logic                         cache_fresh [CACHE_DEPTH];
	int                           cache_cur;
	logic [CFG_W-1:0]             cache_span;

	cache_result_t                pending_results [$];
	logic signed [STEP_OUT_W-1:0] step_pool [$];
	int                           error_count;
	bit                           source_gaps_on;
	bit                           sink_stalls_on;
	int                           stall_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard ceiling on the run: far beyond the slowest legal schedule.
	initial begin
		#(10_000_000);
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// Signed distance at full width; a 64-bit difference cannot overflow.
	function automatic longint step_gap(input logic signed [STEP_OUT_W-1:0] a,
		input logic signed [STEP_OUT_W-1:0] b);
		longint d;
		d = longint'(a) - longint'(b);
		return (d < 0) ? -d : d;
	endfunction

	// Advance the shadow cache by one command and return the result it yields.
	function automatic cache_result_t predict_cache(input cmd_t op,
		input logic signed [STEP_OUT_W-1:0] value, input logic flag);
		cache_result_t res;
		int            span;
		int            idx;
		int            far_idx;
		longint        far_dist;
		longint        d;
		bit            found;
		idx = cache_cur;
		res.hit = 1'b0;
		if (op == CMD_MARK) begin
			cache_fresh[idx] = flag;
		end else begin
			// zero acts as one entry, oversize saturates
			span = (cache_span == 0) ? 1 :
				((cache_span > CACHE_DEPTH) ? CACHE_DEPTH : int'(cache_span));
			if (value == cache_step[idx]) begin
				res.hit = 1'b1;
			end else if (span == 1) begin
				cache_step[idx] = value;
				cache_fresh[idx] = 1'b0;
			end else begin
				found = 1'b0;
				for (int i = 0; i < span; i++) begin
					if (!found && cache_step[i] == value) begin
						idx = i;
						found = 1'b1;
					end
				end
				if (found) begin
					res.hit = 1'b1;
				end else begin
					// strict compare keeps the lowest index on ties
					far_idx = 0;
					far_dist = step_gap(cache_step[0], value);
					for (int i = 1; i < span; i++) begin
						d = step_gap(cache_step[i], value);
						if (d > far_dist) begin
							far_dist = d;
							far_idx = i;
						end
					end
					idx = far_idx;
					cache_step[idx] = value;
					cache_fresh[idx] = 1'b0;
				end
			end
			cache_cur = idx;
		end
		res.index = idx[IDX_OUT_W-1:0];
		res.step = cache_step[idx];
		res.flag = cache_fresh[idx];
		return res;
	endfunction

	// Drive one command transaction from a falling edge, hold it until the
	// unit takes it, then record the expected result. Drop valid only when a
	// gap follows, so back-to-back transactions keep valid high.
	task automatic send_command(input cmd_t op, input logic signed [STEP_OUT_W-1:0] value,
		input logic flag);
		int gap;
		cmd_ch.valid = 1'b1;
		cmd_ch.command = op;
		cmd_ch.step_value = value;
		cmd_ch.up_to_date = flag;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		pending_results.push_back(predict_cache(op, value, flag));
		@(negedge clk);
		gap = source_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			cmd_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Hold the command channel until every expected result is back, then let
	// the unit settle so that a register write finds it idle.
	task automatic wait_drained();
		cmd_ch.valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write entries_in_use; call only once drained.
	task automatic write_span(input logic [CFG_W-1:0] value);
		cfg_ch.valid = 1'b1;
		cfg_ch.data = value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cache_span = value;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Result side: random stalls on ready, compare every result transaction
	// against the oldest expectation, field by field.
	initial begin
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				rsp_ch.ready = 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready = 1'b1;
				if (sink_stalls_on)
					stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : result_check
		cache_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_error("result transaction with no command outstanding");
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.current_index !== want.index)
					report_error($sformatf("current_index got %0d expected %0d",
						rsp_ch.current_index, want.index));
				if (rsp_ch.current_step !== want.step)
					report_error($sformatf("current_step got %h expected %h",
						rsp_ch.current_step, want.step));
				if (rsp_ch.current_valid !== want.flag)
					report_error($sformatf("current_valid got %b expected %b",
						rsp_ch.current_valid, want.flag));
				if (rsp_ch.was_hit !== want.hit)
					report_error($sformatf("was_hit got %b expected %b",
						rsp_ch.was_hit, want.hit));
			end
		end
	end

	// Reset contents, the full-scale values and tie-breaking among equal
	// distances (all entries start at zero, so the first miss lands on 0).
	task automatic test_reset_and_extremes();
		send_command(CMD_SELECT, 32'sh0000_0000, 1'b1);   // current-entry hit, flag ignored
		send_command(CMD_MARK, 32'sh7FFF_FFFF, 1'b1);     // step value ignored
		send_command(CMD_MARK, 32'sh8000_0000, 1'b0);
		send_command(CMD_SELECT, 32'sh7FFF_FFFF, 1'b0);   // tie: lowest index replaced
		send_command(CMD_MARK, 32'sh0, 1'b1);
		send_command(CMD_SELECT, 32'sh8000_0000, 1'b1);   // widest possible distance
		send_command(CMD_SELECT, 32'sh0000_0000, 1'b0);   // hit found by the scan
		send_command(CMD_SELECT, -32'sh0000_0001, 1'b0);
		send_command(CMD_SELECT, 32'sh0000_0001, 1'b1);
		send_command(CMD_SELECT, 32'sh8000_0000, 1'b0);
	endtask

	// Register extremes: zero behaves as one entry, fifteen saturates.
	task automatic test_register_limits();
		wait_drained();
		write_span(4'd0);
		send_command(CMD_SELECT, 32'sh0005_0000, 1'b0);   // overwrite in place
		send_command(CMD_MARK, 32'sh0, 1'b1);
		send_command(CMD_SELECT, 32'sh0005_0000, 1'b0);
		send_command(CMD_SELECT, -32'sh0005_0000, 1'b1);
		wait_drained();
		write_span(4'd15);
		send_command(CMD_SELECT, 32'sh0001_8000, 1'b0);
		send_command(CMD_SELECT, 32'sh7FFF_FFFF, 1'b0);
		send_command(CMD_MARK, 32'sh0, 1'b1);
	endtask

	// Shrink the register while the current entry sits beyond the new span.
	task automatic test_current_outside_span();
		int                           j;
		logic signed [STEP_OUT_W-1:0] outside;
		wait_drained();
		write_span(4'd8);
		for (int k = 0; k < 6; k++)
			send_command(CMD_SELECT, (k - 3) * 32'sh1234_5678 + 32'sh0000_00C1, 1'b0);
		// pick the highest entry whose value the match scan lands on
		j = 0;
		for (int i = CACHE_DEPTH - 1; i > 0 && j == 0; i--) begin
			j = i;
			for (int m = 0; m < i; m++)
				if (cache_step[m] == cache_step[i])
					j = 0;
		end
		outside = cache_step[j];
		send_command(CMD_SELECT, outside, 1'b0);
		send_command(CMD_MARK, 32'sh0, 1'b1);
		wait_drained();
		write_span(4'd2);
		send_command(CMD_SELECT, outside, 1'b0);          // still compared first
		send_command(CMD_SELECT, 32'sh0003_0000, 1'b0);   // replaced within the span
		send_command(CMD_SELECT, outside, 1'b1);          // no longer searched
	endtask

	// Random traffic at one register setting: selects drawn mostly from a
	// small pool of values so hits and replacements both stay frequent.
	task automatic test_random_traffic(input logic [CFG_W-1:0] span, input int count);
		int                           pick;
		int                           k;
		int                           r;
		logic signed [STEP_OUT_W-1:0] v;
		wait_drained();
		write_span(span);
		source_gaps_on = ($urandom_range(0, 3) != 0);
		sink_stalls_on = ($urandom_range(0, 3) != 0);
		step_pool.delete();
		repeat (int'(span > CACHE_DEPTH ? CACHE_DEPTH : span) + 3) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				step_pool.push_back(32'sh8000_0000 + $urandom_range(0, 3));
			else if (r < 20)
				step_pool.push_back(32'sh7FFF_FFFF - $urandom_range(0, 3));
			else if (r < 60)
				step_pool.push_back($signed($urandom_range(0, 4095)) - 2048);
			else
				step_pool.push_back($urandom);
		end
		for (int n = 0; n < count; n++) begin
			// hold off once per phase until the unit has drained
			if (n == count / 2)
				wait_drained();
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				send_command(CMD_MARK, $urandom, 1'($urandom_range(0, 1)));
			end else begin
				k = $urandom_range(0, step_pool.size() - 1);
				if (pick < 75)
					v = step_pool[k];
				else if (pick < 88)
					v = step_pool[k] + $signed($urandom_range(0, 4)) - 2;
				else
					v = $urandom;
				send_command(CMD_SELECT, v, 1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = CMD_SELECT;
		cmd_ch.step_value = '0;
		cmd_ch.up_to_date = 1'b0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		error_count = 0;
		stall_left = 0;
		source_gaps_on = 1'b0;
		sink_stalls_on = 1'b0;
		for (int i = 0; i < CACHE_DEPTH; i++) begin
			cache_step[i] = '0;
			cache_fresh[i] = 1'b0;
		end
		cache_cur = 0;
		cache_span = 4'd8;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part runs with gaps on both sides
		source_gaps_on = 1'b1;
		sink_stalls_on = 1'b1;
		test_reset_and_extremes();
		test_register_limits();
		test_current_outside_span();

		test_random_traffic(4'd8, 300);
		test_random_traffic(4'd1, 150);
		test_random_traffic(4'd0, 100);
		test_random_traffic(4'd15, 200);
		test_random_traffic(4'd3, 250);
		test_random_traffic(4'd5, 250);
		test_random_traffic(4'd2, 200);
		test_random_traffic(4'd7, 250);
		test_random_traffic(4'd8, 200);

		// wait out the last results, then watch for stray transactions
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
